@@ hdl/spr_pkg.sv @@
// Shared types, constants and register map for the seasonal pixel recolor unit.
package spr_pkg;

  localparam int CHANNEL_MAX = 255;
  localparam int CFG_W       = 40;
  localparam int CFG_IDX_W   = 3;

  localparam logic [CFG_IDX_W-1:0] REG_GREY_SETTINGS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SUM_BOUNDS       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RATIO_FACTORS    = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DARK_OFFSETS     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BRIGHT_OFFSETS   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_GREENISH_OFFSETS = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_REST_OFFSETS     = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_WATER      = 3'd7;

  typedef enum logic [2:0] {
    CLS_WATER    = 3'd0,
    CLS_GREY     = 3'd1,
    CLS_DARK     = 3'd2,
    CLS_BRIGHT   = 3'd3,
    CLS_GREENISH = 3'd4,
    CLS_REST     = 3'd5
  } cls_t;

  typedef struct packed {
    logic signed [8:0] red;
    logic signed [8:0] green;
    logic signed [8:0] blue;
  } offs_t;

  typedef struct packed {
    logic       grey_en;
    logic [9:0] grey_tol;
    logic [9:0] grey_smin;
    logic [7:0] scatter_fac;
    logic [9:0] dark_lo;
    logic [9:0] dark_hi;
    logic [9:0] bright_lo;
    logic [9:0] bright_hi;
    logic [7:0] weight_blue;
    logic [7:0] weight_green;
    offs_t      dark_offs;
    offs_t      bright_offs;
    offs_t      greenish_offs;
    offs_t      rest_offs;
    logic       spare_water;
  } spr_cfg_t;

endpackage

@@ hdl/spr_cfg.sv @@
// Configuration register file with decoded field view.
module spr_cfg (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [spr_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [spr_pkg::CFG_W-1:0]          cfg_data,
  output spr_pkg::spr_cfg_t                  cfg
);
  import spr_pkg::*;

  logic [28:0] grey_settings;
  logic [39:0] sum_bounds;
  logic [15:0] ratio_factors;
  logic [26:0] dark_offsets;
  logic [26:0] bright_offsets;
  logic [26:0] greenish_offsets;
  logic [26:0] rest_offsets;
  logic        spare_water;

  always_ff @(posedge clk) begin
    if (rst) begin
      grey_settings    <= '0;
      sum_bounds       <= '0;
      ratio_factors    <= '0;
      dark_offsets     <= '0;
      bright_offsets   <= '0;
      greenish_offsets <= '0;
      rest_offsets     <= '0;
      spare_water      <= 1'b0;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GREY_SETTINGS:    grey_settings    <= cfg_data[28:0];
        REG_SUM_BOUNDS:       sum_bounds       <= cfg_data[39:0];
        REG_RATIO_FACTORS:    ratio_factors    <= cfg_data[15:0];
        REG_DARK_OFFSETS:     dark_offsets     <= cfg_data[26:0];
        REG_BRIGHT_OFFSETS:   bright_offsets   <= cfg_data[26:0];
        REG_GREENISH_OFFSETS: greenish_offsets <= cfg_data[26:0];
        REG_REST_OFFSETS:     rest_offsets     <= cfg_data[26:0];
        REG_SPARE_WATER:      spare_water      <= cfg_data[0];
        default: ;
      endcase
    end
  end

  function automatic offs_t unpack_offs(input logic [26:0] v);
    offs_t o;
    o.red   = v[8:0];
    o.green = v[17:9];
    o.blue  = v[26:18];
    return o;
  endfunction

  always_comb begin
    cfg.grey_en       = grey_settings[0];
    cfg.grey_tol      = grey_settings[10:1];
    cfg.grey_smin     = grey_settings[20:11];
    cfg.scatter_fac   = grey_settings[28:21];
    cfg.dark_lo       = sum_bounds[9:0];
    cfg.dark_hi       = sum_bounds[19:10];
    cfg.bright_lo     = sum_bounds[29:20];
    cfg.bright_hi     = sum_bounds[39:30];
    cfg.weight_blue   = ratio_factors[7:0];
    cfg.weight_green  = ratio_factors[15:8];
    cfg.dark_offs     = unpack_offs(dark_offsets);
    cfg.bright_offs   = unpack_offs(bright_offsets);
    cfg.greenish_offs = unpack_offs(greenish_offsets);
    cfg.rest_offs     = unpack_offs(rest_offsets);
    cfg.spare_water   = spare_water;
  end

endmodule

@@ hdl/seasonal_pixel_recolor_unit.sv @@
// Top level: three-stage recolor pipeline (measure, classify, clamp).
// Output path: a pixel passes the stage 1, stage 2 and stage 3 registers in turn;
// out_valid is the stage 3 valid bit.
// Throughput: one pixel per clock; each stage holds its pixel while the next is full.
// Stage 1 sums, checks grey tolerance and multiplies; stage 2 classifies and adds;
// stage 3 clamps into the output register.
// Reset clears all stage valid bits and sets every config register to zero.
module seasonal_pixel_recolor_unit (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_write,
  input  logic [spr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [spr_pkg::CFG_W-1:0]      cfg_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [7:0]                     in_red,
  input  logic [7:0]                     in_green,
  input  logic [7:0]                     in_blue,
  input  logic                           is_water,
  input  logic [15:0]                    rand_red,
  input  logic [15:0]                    rand_green,
  input  logic [15:0]                    rand_blue,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic [7:0]                     out_red,
  output logic [7:0]                     out_green,
  output logic [7:0]                     out_blue,
  output logic [2:0]                     pixel_class
);
  import spr_pkg::*;

  localparam logic signed [10:0] CH_MAX_S = 11'(CHANNEL_MAX);

  spr_cfg_t cfg;

  spr_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  function automatic logic [7:0] absdiff(input logic [7:0] a, input logic [7:0] b);
    return (a > b) ? (a - b) : (b - a);
  endfunction

  function automatic logic signed [10:0] add_offs(input logic [7:0] ch,
                                                  input logic signed [8:0] o);
    return $signed({3'b000, ch}) + $signed({{2{o[8]}}, o});
  endfunction

  function automatic logic [7:0] clamp_ch(input logic signed [10:0] v);
    if (v < 0) return 8'd0;
    if (v > CH_MAX_S) return 8'(CHANNEL_MAX);
    return v[7:0];
  endfunction

  // stage handshake
  logic v1, v2, v3;
  logic rdy1, rdy2, rdy3;

  assign rdy3     = !v3 || out_ready;
  assign rdy2     = !v2 || rdy3;
  assign rdy1     = !v1 || rdy2;
  assign in_ready = rdy1;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      if (rdy1) v1 <= in_valid;
      if (rdy2) v2 <= v1;
      if (rdy3) v3 <= v2;
    end
  end

  // stage 1: sum, tolerance, max, products
  logic [7:0]  s1_red, s1_green, s1_blue, s1_max;
  logic [7:0]  s1_sc_red, s1_sc_green, s1_sc_blue;
  logic [9:0]  s1_sum;
  logic        s1_spared, s1_tol_ok;
  logic [15:0] s1_wbb, s1_wgg;

  logic [23:0] prod_red, prod_green, prod_blue;
  logic [7:0]  max_rg;

  assign prod_red   = 24'(rand_red)   * 24'(cfg.scatter_fac);
  assign prod_green = 24'(rand_green) * 24'(cfg.scatter_fac);
  assign prod_blue  = 24'(rand_blue)  * 24'(cfg.scatter_fac);
  assign max_rg     = (in_green > in_red) ? in_green : in_red;

  always_ff @(posedge clk) begin
    if (rdy1) begin
      s1_red      <= in_red;
      s1_green    <= in_green;
      s1_blue     <= in_blue;
      s1_spared   <= cfg.spare_water && is_water;
      s1_sum      <= 10'(in_red) + 10'(in_green) + 10'(in_blue);
      s1_tol_ok   <= ({2'b00, absdiff(in_red, in_blue)}   < cfg.grey_tol) &&
                     ({2'b00, absdiff(in_red, in_green)}  < cfg.grey_tol) &&
                     ({2'b00, absdiff(in_green, in_blue)} < cfg.grey_tol);
      s1_max      <= (in_blue > max_rg) ? in_blue : max_rg;
      s1_sc_red   <= prod_red[23:16];
      s1_sc_green <= prod_green[23:16];
      s1_sc_blue  <= prod_blue[23:16];
      s1_wbb      <= 16'(cfg.weight_blue)  * 16'(in_blue);
      s1_wgg      <= 16'(cfg.weight_green) * 16'(in_green);
    end
  end

  // stage 2: classify and apply
  cls_t               cls_next;
  offs_t              offs_sel;
  logic signed [10:0] red_next, green_next, blue_next;
  logic               grey_hit;

  cls_t               s2_cls;
  logic signed [10:0] s2_red, s2_green, s2_blue;

  assign grey_hit = cfg.grey_en && s1_tol_ok && (s1_sum > cfg.grey_smin);

  always_comb begin
    if (s1_spared) begin
      cls_next = CLS_WATER;
    end else if (grey_hit) begin
      cls_next = CLS_GREY;
    end else if ((s1_sum < cfg.dark_hi) && (s1_sum > cfg.dark_lo)) begin
      cls_next = CLS_DARK;
    end else if ((s1_sum >= cfg.bright_lo) && (s1_sum < cfg.bright_hi)) begin
      cls_next = CLS_BRIGHT;
    end else if (s1_wbb < s1_wgg) begin
      cls_next = CLS_GREENISH;
    end else begin
      cls_next = CLS_REST;
    end

    case (cls_next)
      CLS_DARK:     offs_sel = cfg.dark_offs;
      CLS_BRIGHT:   offs_sel = cfg.bright_offs;
      CLS_GREENISH: offs_sel = cfg.greenish_offs;
      default:      offs_sel = cfg.rest_offs;
    endcase

    case (cls_next)
      CLS_WATER: begin
        red_next   = $signed({3'b000, s1_red});
        green_next = $signed({3'b000, s1_green});
        blue_next  = $signed({3'b000, s1_blue});
      end
      CLS_GREY: begin
        red_next   = $signed(11'(s1_max) + 11'(s1_sc_red));
        green_next = $signed(11'(s1_max) + 11'(s1_sc_green));
        blue_next  = $signed(11'(s1_max) + 11'(s1_sc_blue));
      end
      default: begin
        red_next   = add_offs(s1_red,   offs_sel.red);
        green_next = add_offs(s1_green, offs_sel.green);
        blue_next  = add_offs(s1_blue,  offs_sel.blue);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rdy2) begin
      s2_cls   <= cls_next;
      s2_red   <= red_next;
      s2_green <= green_next;
      s2_blue  <= blue_next;
    end
  end

  // stage 3: clamp into output register
  cls_t s3_cls;

  always_ff @(posedge clk) begin
    if (rdy3) begin
      s3_cls    <= s2_cls;
      out_red   <= clamp_ch(s2_red);
      out_green <= clamp_ch(s2_green);
      out_blue  <= clamp_ch(s2_blue);
    end
  end

  assign out_valid   = v3;
  assign pixel_class = s3_cls;

  a_backpressure: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> (v1 && v2 && v3 && !out_ready))
    else $error("in_ready low with a free pipeline slot");

  a_stage2_hold: assert property (@(posedge clk) disable iff (rst)
    (v2 && !rdy3) |=> (v2 && $stable(s2_cls) && $stable(s2_red) &&
                       $stable(s2_green) && $stable(s2_blue)))
    else $error("stage 2 transaction lost or changed during stall");

  a_stage1_hold: assert property (@(posedge clk) disable iff (rst)
    (v1 && !rdy2) |=> (v1 && $stable(s1_sum) && $stable(s1_red)))
    else $error("stage 1 transaction lost or changed during stall");

  a_water_needs_spare: assert property (@(posedge clk) disable iff (rst)
    (v2 && s2_cls == CLS_WATER) |-> cfg.spare_water)
    else $error("water class without sparing enabled");

  a_grey_needs_enable: assert property (@(posedge clk) disable iff (rst)
    (v2 && s2_cls == CLS_GREY) |-> cfg.grey_en)
    else $error("grey class with grey branch disabled");

endmodule
